### rtl/iir_pkg.sv
// ----------------------------------------------------------------------------
// iir_pkg
// Shared types and constants of the direct form I IIR filter core.
// ----------------------------------------------------------------------------
`default_nettype none

package iir_pkg;

    // Fixed-point format of coefficients and the accumulator
    localparam int COEFF_W   = 16;
    localparam int FRAC_BITS = 12;
    localparam int ACC_W     = 40;

    // Tap limits and the width of the term counter (2*MAX_ORDER+1 terms)
    localparam int MAX_ORDER = 8;
    localparam int TERM_W    = $clog2(2 * MAX_ORDER + 1);
    localparam int FB_IDX_W  = $clog2(MAX_ORDER);
    localparam int FF_IDX_W  = $clog2(MAX_ORDER + 1);

    // Register file geometry: 64-bit registers at 8-byte strides
    localparam int REG_W   = 64;
    localparam int PADDR_W = 6;
    localparam int LANES   = REG_W / COEFF_W;

    typedef logic signed [COEFF_W-1:0] t_coeff;

    typedef enum logic [2:0] {
        REG_FB_LOW     = 3'd0,
        REG_FB_HIGH    = 3'd1,
        REG_FF_FIRST   = 3'd2,
        REG_FF_SECOND  = 3'd3,
        REG_FF_LAST    = 3'd4
    } t_reg_idx;

    // Controller to datapath commands
    typedef struct packed {
        logic              load;    // capture the new sample, clear the accumulator
        logic              issue;   // multiply the selected term
        logic [TERM_W-1:0] term;    // term number, 0 is b0*u[n]
        logic              commit;  // saturate, write the output, shift the histories
    } t_ctrl_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;             // output register can take a result this cycle
    } t_ctrl_sts;

endpackage

`default_nettype wire

### rtl/iir_in_if.sv
// ----------------------------------------------------------------------------
// iir_in_if
// Input sample channel: valid/ready handshake with one signed sample.
// ----------------------------------------------------------------------------
`default_nettype none

interface iir_in_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

`default_nettype wire

### rtl/iir_out_if.sv
// ----------------------------------------------------------------------------
// iir_out_if
// Output sample channel: valid/ready handshake with a sample and a clip flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface iir_out_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_out;
    logic                           clipped;

    modport source (output valid, output sample_out, output clipped, input ready);
    modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

`default_nettype wire

### rtl/iir_regs.sv
// ----------------------------------------------------------------------------
// iir_regs
// APB coefficient registers; unpacks the Q4.12 lanes into coefficient arrays.
// ----------------------------------------------------------------------------
`default_nettype none

module iir_regs (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_psel,
    input  wire logic                        i_penable,
    input  wire logic                        i_pwrite,
    input  wire logic [iir_pkg::PADDR_W-1:0] i_paddr,
    input  wire logic [iir_pkg::REG_W-1:0]   i_pwdata,
    output logic      [iir_pkg::REG_W-1:0]   o_prdata,
    output iir_pkg::t_coeff                  o_fb_coeff [iir_pkg::MAX_ORDER],
    output iir_pkg::t_coeff                  o_ff_coeff [iir_pkg::MAX_ORDER+1]
);
    import iir_pkg::*;

    logic [REG_W-1:0]   r_fb_low;
    logic [REG_W-1:0]   r_fb_high;
    logic [REG_W-1:0]   r_ff_first;
    logic [REG_W-1:0]   r_ff_second;
    logic [COEFF_W-1:0] r_ff_last;
    logic               w_wr;
    t_reg_idx           w_idx;

    assign w_wr  = i_psel && i_penable && i_pwrite;
    assign w_idx = t_reg_idx'(i_paddr[PADDR_W-1:3]);

    // Write the addressed register; drop writes beyond the list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fb_low    <= '0;
            r_fb_high   <= '0;
            r_ff_first  <= '0;
            r_ff_second <= '0;
            r_ff_last   <= '0;
        end else if (w_wr) begin
            case (w_idx)
                REG_FB_LOW:    r_fb_low    <= i_pwdata;
                REG_FB_HIGH:   r_fb_high   <= i_pwdata;
                REG_FF_FIRST:  r_ff_first  <= i_pwdata;
                REG_FF_SECOND: r_ff_second <= i_pwdata;
                REG_FF_LAST:   r_ff_last   <= i_pwdata[COEFF_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        case (w_idx)
            REG_FB_LOW:    o_prdata = r_fb_low;
            REG_FB_HIGH:   o_prdata = r_fb_high;
            REG_FF_FIRST:  o_prdata = r_ff_first;
            REG_FF_SECOND: o_prdata = r_ff_second;
            REG_FF_LAST:   o_prdata = REG_W'(r_ff_last);
            default:       o_prdata = '0;
        endcase
    end

    // Unpack lanes, lowest lane first
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            o_fb_coeff[i]         = r_fb_low[COEFF_W*i +: COEFF_W];
            o_fb_coeff[i+LANES]   = r_fb_high[COEFF_W*i +: COEFF_W];
            o_ff_coeff[i]         = r_ff_first[COEFF_W*i +: COEFF_W];
            o_ff_coeff[i+LANES]   = r_ff_second[COEFF_W*i +: COEFF_W];
        end
        o_ff_coeff[MAX_ORDER] = r_ff_last;
    end

endmodule

`default_nettype wire

### rtl/iir_ctrl.sv
// ----------------------------------------------------------------------------
// iir_ctrl
// Sequencer: accepts an item, steps the shared MAC through all terms,
// drains the product register and commits the result.
// ----------------------------------------------------------------------------
`default_nettype none

module iir_ctrl #(
    parameter int ORDER = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire iir_pkg::t_ctrl_sts i_sts,
    output iir_pkg::t_ctrl_cmd      o_cmd
);
    import iir_pkg::*;

    localparam logic [TERM_W-1:0] LAST_TERM = TERM_W'(2 * ORDER);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAC,
        S_DRAIN,
        S_COMMIT
    } t_state;

    t_state            r_state;
    t_state            n_state;
    logic [TERM_W-1:0] r_term;
    logic [TERM_W-1:0] n_term;

    // Decode commands and next state
    always_comb begin
        n_state      = r_state;
        n_term       = r_term;
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        o_cmd.term   = r_term;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
                if (i_in_valid) begin
                    n_term  = '0;
                    n_state = S_MAC;
                end
            end
            S_MAC: begin
                o_cmd.issue = 1'b1;
                if (r_term == LAST_TERM) begin
                    n_state = S_DRAIN;
                end else begin
                    n_term = r_term + 1'b1;
                end
            end
            S_DRAIN: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                o_cmd.commit = i_sts.out_free;
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold state and term counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_term  <= '0;
        end else begin
            r_state <= n_state;
            r_term  <= n_term;
        end
    end

endmodule

`default_nettype wire

### rtl/iir_datapath.sv
// ----------------------------------------------------------------------------
// iir_datapath
// Sample histories, shared multiplier with product register, 40-bit
// accumulator, shift and saturation, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module iir_datapath #(
    parameter int ORDER        = 8,
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire iir_pkg::t_ctrl_cmd             i_cmd,
    output iir_pkg::t_ctrl_sts                  o_sts,
    input  wire iir_pkg::t_coeff                i_fb_coeff [iir_pkg::MAX_ORDER],
    input  wire iir_pkg::t_coeff                i_ff_coeff [iir_pkg::MAX_ORDER+1],
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_sample_in,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]      o_sample_out,
    output logic                                o_clipped
);
    import iir_pkg::*;

    localparam int IDX_W  = (ORDER > 1) ? $clog2(ORDER) : 1;
    localparam int PROD_W = COEFF_W + SAMPLE_WIDTH;
    localparam int SH_W   = ACC_W - FRAC_BITS;

    logic signed [SAMPLE_WIDTH-1:0] r_u_hist [ORDER];
    logic signed [SAMPLE_WIDTH-1:0] r_y_hist [ORDER];
    logic signed [SAMPLE_WIDTH-1:0] r_u_cur;
    logic signed [ACC_W-1:0]        r_prod;
    logic                           r_prod_vld;
    logic signed [ACC_W-1:0]        r_acc;
    logic                           r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_out_sample;
    logic                           r_out_clip;

    logic [TERM_W-1:0]              w_term_m1;
    logic [IDX_W-1:0]               w_hist_idx;
    t_coeff                         w_coeff;
    logic signed [SAMPLE_WIDTH-1:0] w_samp;
    logic signed [PROD_W-1:0]       w_prod;
    logic signed [ACC_W-1:0]        w_prod_ext;
    logic signed [SH_W-1:0]         w_shift;
    logic signed [SAMPLE_WIDTH-1:0] w_y;
    logic                           w_clip;

    // Select coefficient and sample for the current term
    assign w_term_m1  = i_cmd.term - 1'b1;
    assign w_hist_idx = w_term_m1[IDX_W:1];

    always_comb begin
        if (i_cmd.term == '0) begin
            w_coeff = i_ff_coeff[0];
            w_samp  = r_u_cur;
        end else if (i_cmd.term[0]) begin
            w_coeff = i_fb_coeff[w_term_m1[FB_IDX_W:1]];
            w_samp  = r_y_hist[w_hist_idx];
        end else begin
            w_coeff = i_ff_coeff[i_cmd.term[FF_IDX_W:1]];
            w_samp  = r_u_hist[w_hist_idx];
        end
    end

    assign w_prod = w_coeff * w_samp;

    // Fit the product to the accumulator width (wrap when wider)
    generate
        if (PROD_W >= ACC_W) begin : g_prod_trunc
            assign w_prod_ext = w_prod[ACC_W-1:0];
        end else begin : g_prod_sext
            assign w_prod_ext = ACC_W'(w_prod);
        end
    endgenerate

    // Shift right by the fraction bits, then saturate to the sample width
    assign w_shift = r_acc[ACC_W-1:FRAC_BITS];

    generate
        if (SAMPLE_WIDTH >= SH_W) begin : g_sat_none
            assign w_y    = SAMPLE_WIDTH'(w_shift);
            assign w_clip = 1'b0;
        end else begin : g_sat
            logic [SH_W-SAMPLE_WIDTH:0] w_hi;
            logic                       w_fits;
            assign w_hi   = w_shift[SH_W-1:SAMPLE_WIDTH-1];
            assign w_fits = (&w_hi) || !(|w_hi);
            assign w_clip = !w_fits;
            always_comb begin
                if (w_fits) begin
                    w_y = w_shift[SAMPLE_WIDTH-1:0];
                end else if (w_shift[SH_W-1]) begin
                    w_y = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
                end else begin
                    w_y = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
                end
            end
        end
    endgenerate

    // Register the product, accumulate it in the following cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_cmd.issue;
        end
        r_prod <= w_prod_ext;
        if (i_cmd.load) begin
            r_u_cur <= i_sample_in;
            r_acc   <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + r_prod;
        end
    end

    // Shift both histories on commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ORDER; i++) begin
                r_u_hist[i] <= '0;
                r_y_hist[i] <= '0;
            end
        end else if (i_cmd.commit) begin
            r_u_hist[0] <= r_u_cur;
            r_y_hist[0] <= w_y;
            for (int i = 1; i < ORDER; i++) begin
                r_u_hist[i] <= r_u_hist[i-1];
                r_y_hist[i] <= r_y_hist[i-1];
            end
        end
    end

    // Output register: load on commit, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.commit) begin
            r_out_sample <= w_y;
            r_out_clip   <= w_clip;
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_sample_out   = r_out_sample;
    assign o_clipped      = r_out_clip;

endmodule

`default_nettype wire

### rtl/iir_direct_form_one_filter_core.sv
// ----------------------------------------------------------------------------
// iir_direct_form_one_filter_core
// Direct form I IIR filter, up to eight feedback and nine forward taps.
// ----------------------------------------------------------------------------
// One input sample gives one output sample. A single shared multiplier
// works through the terms one per cycle: the sample is accepted, its
// 2*ORDER+1 terms are multiplied, the last product is added, and the
// result is saturated and committed; no new sample is taken before the
// commit, which waits while the previous result still sits unread in the
// output register. Feedback terms are added, not subtracted. Coefficients
// are signed Q4.12, up to four to a 64-bit register at byte address 8*i,
// and are written over APB only while the core is idle; the user must keep
// to this, the core does not enforce it. The 40-bit sum is shifted right
// by 12 and saturated; clipped flags saturation. Lower orders are set by writing zero coefficients.
// ----------------------------------------------------------------------------
`default_nettype none

module iir_direct_form_one_filter_core #(
    parameter int ORDER        = 8,
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    iir_in_if.sink                           i_sample,
    iir_out_if.source                        o_result,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [iir_pkg::PADDR_W-1:0] paddr,
    input  wire logic [iir_pkg::REG_W-1:0]   pwdata,
    output logic      [iir_pkg::REG_W-1:0]   prdata,
    output logic                             pready
);
    import iir_pkg::*;

    t_ctrl_cmd w_cmd;
    t_ctrl_sts w_sts;
    t_coeff    w_fb_coeff [MAX_ORDER];
    t_coeff    w_ff_coeff [MAX_ORDER+1];
    logic      w_in_ready;

    assign pready         = 1'b1;
    assign i_sample.ready = w_in_ready;

    // Coefficient registers
    iir_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .o_prdata   (prdata),
        .o_fb_coeff (w_fb_coeff),
        .o_ff_coeff (w_ff_coeff)
    );

    // Sequencer
    iir_ctrl #(
        .ORDER (ORDER)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_sample.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Datapath
    iir_datapath #(
        .ORDER        (ORDER),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_fb_coeff   (w_fb_coeff),
        .i_ff_coeff   (w_ff_coeff),
        .i_sample_in  (i_sample.sample_in),
        .o_out_valid  (o_result.valid),
        .i_out_ready  (o_result.ready),
        .o_sample_out (o_result.sample_out),
        .o_clipped    (o_result.clipped)
    );

endmodule

`default_nettype wire
